// ----- rtl/line_follow_turn_sequencer_macros.svh -----
// Assertion macros used by the file that checks its own logic.
`ifndef LINE_FOLLOW_TURN_SEQUENCER_MACROS_SVH
`define LINE_FOLLOW_TURN_SEQUENCER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LFTS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lfts assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define LFTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lfts assertion failed");

`endif

// ----- rtl/lfts_pkg.sv -----
package lfts_pkg;

  localparam int COUNT_WIDTH_DEF = 32;
  localparam int ENC_W = 32;
  localparam int CROSS_W = 16;
  localparam int PPR_W = 16;
  localparam int BASE_W = 7;
  localparam int SPEED_W = 8;
  localparam int CLASS_W = 4;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W = 1;

  localparam logic [BASE_W-1:0] BASE_SPEED_RESET = 7'd25;
  localparam logic [PPR_W-1:0] PPR_RESET = 16'd1000;
  localparam logic [BASE_W-1:0] SPEED_CAP = 7'd100;

  localparam logic [CFG_IDX_W-1:0] CFG_BASE_SPEED = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PULSES_PER_REV = 1'b1;

  localparam logic [CLASS_W-1:0] CLASS_CENTRE = 4'd0;
  localparam logic [CLASS_W-1:0] CLASS_LEFT1 = 4'd1;
  localparam logic [CLASS_W-1:0] CLASS_LEFT2 = 4'd2;
  localparam logic [CLASS_W-1:0] CLASS_LEFT3 = 4'd3;
  localparam logic [CLASS_W-1:0] CLASS_RIGHT1 = 4'd4;
  localparam logic [CLASS_W-1:0] CLASS_RIGHT2 = 4'd5;
  localparam logic [CLASS_W-1:0] CLASS_RIGHT3 = 4'd6;
  localparam logic [CLASS_W-1:0] CLASS_CROSS = 4'd7;

  typedef enum logic [2:0] {
    FN_FOLLOW  = 3'd0,
    FN_RIGHT   = 3'd1,
    FN_LEFT    = 3'd2,
    FN_AROUND  = 3'd3,
    FN_ENABLE  = 3'd4,
    FN_DISABLE = 3'd5
  } func_t;

  typedef enum logic [2:0] {
    MODE_FOLLOW = 3'd0,
    MODE_RIGHT  = 3'd1,
    MODE_LEFT   = 3'd2,
    MODE_AROUND = 3'd3,
    MODE_OFF    = 3'd4
  } mode_t;

  typedef struct packed {
    func_t                    func;
    logic [CLASS_W-1:0]       line_code;
    logic [CROSS_W-1:0]       turn_cross;
    logic [3:0][ENC_W-1:0]    enc;
  } item_t;

  typedef struct packed {
    logic [3:0] quarter;
    logic       half_all;
    logic       full_all;
  } reach_t;

  typedef struct packed {
    logic [3:0]              drive_mask;
    logic [3:0][SPEED_W-1:0] speed;
    mode_t                   mode_now;
    logic [CROSS_W-1:0]      crosses_seen;
  } result_t;

  // Floor of x/3 for x up to 200, by the reciprocal 171/512.
  function automatic logic [BASE_W-1:0] div3(input logic [SPEED_W-1:0] x);
    logic [15:0] p;
    p = 16'(x) * 16'd171;
    return p[15:9];
  endfunction

endpackage

// ----- rtl/lfts_in_if.sv -----
interface lfts_in_if;
  import lfts_pkg::*;

  logic               valid;
  logic               ready;
  logic [2:0]         func;
  logic [CLASS_W-1:0] line_code;
  logic [CROSS_W-1:0] turn_cross;
  logic [ENC_W-1:0]   enc_a;
  logic [ENC_W-1:0]   enc_b;
  logic [ENC_W-1:0]   enc_c;
  logic [ENC_W-1:0]   enc_d;

  modport source (
    output valid, func, line_code, turn_cross, enc_a, enc_b, enc_c, enc_d,
    input  ready
  );

  modport sink (
    input  valid, func, line_code, turn_cross, enc_a, enc_b, enc_c, enc_d,
    output ready
  );
endinterface

// ----- rtl/lfts_out_if.sv -----
interface lfts_out_if;
  import lfts_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [3:0]                drive_mask;
  logic signed [SPEED_W-1:0] speed_a;
  logic signed [SPEED_W-1:0] speed_b;
  logic signed [SPEED_W-1:0] speed_c;
  logic signed [SPEED_W-1:0] speed_d;
  logic [2:0]                mode_now;
  logic [CROSS_W-1:0]        crosses_seen;

  modport source (
    output valid, drive_mask, speed_a, speed_b, speed_c, speed_d, mode_now, crosses_seen,
    input  ready
  );

  modport sink (
    input  valid, drive_mask, speed_a, speed_b, speed_c, speed_d, mode_now, crosses_seen,
    output ready
  );
endinterface

// ----- rtl/lfts_delta.sv -----
module lfts_delta #(
  parameter int COUNT_WIDTH = lfts_pkg::COUNT_WIDTH_DEF
) (
  input  logic [3:0][COUNT_WIDTH-1:0] enc,
  input  logic [3:0][COUNT_WIDTH-1:0] snap,
  input  logic                        entry,
  input  logic [lfts_pkg::PPR_W-1:0]  pulses_per_rev,
  output lfts_pkg::reach_t            reach
);
  import lfts_pkg::*;

  logic [COUNT_WIDTH-1:0] quarter_thr;
  logic [COUNT_WIDTH-1:0] half_thr;
  logic [COUNT_WIDTH-1:0] full_thr;
  logic [3:0][COUNT_WIDTH-1:0] delta;
  logic [3:0] half_hit;
  logic [3:0] full_hit;

  assign quarter_thr = COUNT_WIDTH'(pulses_per_rev >> 2);
  assign half_thr    = COUNT_WIDTH'(pulses_per_rev >> 1);
  assign full_thr    = COUNT_WIDTH'(pulses_per_rev);

  // On a turn entry the snapshot is taken from this very item, so every delta is zero.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      delta[i]        = entry ? '0 : enc[i] - snap[i];
      reach.quarter[i] = delta[i] >= quarter_thr;
      half_hit[i]     = delta[i] >= half_thr;
      full_hit[i]     = delta[i] >= full_thr;
    end
    reach.half_all = &half_hit;
    reach.full_all = &full_hit;
  end
endmodule

// ----- rtl/lfts_ctrl.sv -----
module lfts_ctrl #(
  parameter int COUNT_WIDTH = lfts_pkg::COUNT_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         fire,
  input  lfts_pkg::item_t              item,
  input  logic [3:0][COUNT_WIDTH-1:0]  enc,
  input  logic [lfts_pkg::BASE_W-1:0]  base_speed,
  input  lfts_pkg::reach_t             reach,
  output logic                         entry,
  output logic [3:0][COUNT_WIDTH-1:0]  snap,
  output lfts_pkg::result_t            result
);
  import lfts_pkg::*;

  mode_t                       mode_r, mode_nxt;
  logic [CROSS_W-1:0]          cross_r, cross_nxt;
  logic [CROSS_W-1:0]          last_r, last_nxt;
  logic [CLASS_W-1:0]          prior_r, prior_nxt;
  logic [CLASS_W-1:0]          cur_r, cur_nxt;
  logic [3:0][COUNT_WIDTH-1:0] snap_r, snap_nxt;

  logic [BASE_W-1:0]  b;
  logic [SPEED_W-1:0] sb, sb2, sb1, sneg;
  logic               turn_cmd, own, centre, done;
  mode_t              turn_mode;
  logic [3:0]              drv;
  logic [3:0][SPEED_W-1:0] spd;

  assign b    = (base_speed > SPEED_CAP) ? SPEED_CAP : base_speed;
  assign sb   = SPEED_W'(b);
  assign sb2  = SPEED_W'(div3({b, 1'b0}));
  assign sb1  = SPEED_W'(div3(sb));
  assign sneg = SPEED_W'(0) - sb;

  assign turn_cmd  = item.func inside {FN_RIGHT, FN_LEFT, FN_AROUND};
  assign turn_mode = mode_t'(3'(item.func));
  assign centre    = item.line_code == CLASS_CENTRE;
  assign entry     = turn_cmd && item.turn_cross == cross_r && mode_r == MODE_FOLLOW
                     && last_r != item.turn_cross;
  assign own       = turn_cmd && (entry || mode_r == turn_mode);
  assign done      = (item.func == FN_AROUND) ? (reach.full_all && centre)
                                              : (&reach.quarter && reach.half_all && centre);
  assign snap      = snap_r;

  always_comb begin
    mode_nxt  = mode_r;
    cross_nxt = cross_r;
    last_nxt  = last_r;
    prior_nxt = prior_r;
    cur_nxt   = cur_r;
    snap_nxt  = snap_r;
    case (item.func)
      FN_FOLLOW: begin
        if (mode_r == MODE_FOLLOW) begin
          prior_nxt = cur_r;
          cur_nxt   = item.line_code;
          if (item.line_code == CLASS_CROSS && cur_r != CLASS_CROSS) begin
            cross_nxt = cross_r + 1'b1;
          end
        end
      end
      FN_RIGHT, FN_LEFT, FN_AROUND: begin
        if (entry) begin
          last_nxt = item.turn_cross;
          snap_nxt = enc;
          mode_nxt = turn_mode;
        end
        if (own && done) begin
          mode_nxt = MODE_FOLLOW;
        end
      end
      FN_ENABLE:  mode_nxt = MODE_FOLLOW;
      FN_DISABLE: mode_nxt = MODE_OFF;
      default: ;
    endcase
  end

  always_comb begin
    drv = '0;
    spd = '0;
    case (item.func)
      FN_FOLLOW: begin
        if (mode_r == MODE_FOLLOW) begin
          case (item.line_code)
            CLASS_CENTRE: begin drv = 4'hF; spd = {sb, sb, sb, sb}; end
            CLASS_LEFT1:  begin drv = 4'hF; spd = {sb, sb, sb2, sb2}; end
            CLASS_LEFT2:  begin drv = 4'hF; spd = {sb, sb, sb1, sb1}; end
            CLASS_LEFT3:  begin drv = 4'hF; spd = {sb, sb, 8'd0, 8'd0}; end
            CLASS_RIGHT1: begin drv = 4'hF; spd = {sb2, sb2, sb, sb}; end
            CLASS_RIGHT2: begin drv = 4'hF; spd = {sb1, sb1, sb, sb}; end
            CLASS_RIGHT3: begin drv = 4'hF; spd = {8'd0, 8'd0, sb, sb}; end
            default: ;
          endcase
        end
      end
      FN_RIGHT, FN_LEFT, FN_AROUND: begin
        if (entry) begin
          drv = 4'hF;
          spd = (item.func == FN_AROUND) ? {sneg, sneg, sb, sb} : {sb, sb, sb, sb};
        end
        if (own && item.func != FN_AROUND) begin
          if (&reach.quarter) begin
            drv = 4'hF;
            spd = (item.func == FN_RIGHT) ? {sneg, sneg, sb, sb} : {sb, sb, sneg, sneg};
          end else begin
            for (int i = 0; i < 4; i++) begin
              if (reach.quarter[i]) begin
                drv[i] = 1'b1;
                spd[i] = '0;
              end
            end
          end
        end
      end
      default: ;
    endcase
    result.drive_mask   = drv;
    result.speed        = spd;
    result.mode_now     = mode_nxt;
    result.crosses_seen = cross_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_FOLLOW;
      cross_r <= '0;
      last_r  <= '0;
      prior_r <= CLASS_CROSS;
      cur_r   <= CLASS_CROSS;
      snap_r  <= '0;
    end else if (fire) begin
      mode_r  <= mode_nxt;
      cross_r <= cross_nxt;
      last_r  <= last_nxt;
      prior_r <= prior_nxt;
      cur_r   <= cur_nxt;
      snap_r  <= snap_nxt;
    end
  end
endmodule

// ----- rtl/line_follow_turn_sequencer.sv -----
// Mode sequencer for a four-wheel line follower. Every transfer on the input
// channel carries one command with the line-sensor class and four encoder counts,
// and yields exactly one result transfer with the motor speeds, the mode and the
// cross count. The block takes one item per clock cycle while the sink keeps
// ready high: an item is held in the input register, the mode logic and four
// encoder subtract-compare paths settle from it, and the result lands in the
// output register. Configuration must be written only while no item is in
// flight; the block itself does not enforce this.
`include "line_follow_turn_sequencer_macros.svh"

module line_follow_turn_sequencer #(
  parameter int COUNT_WIDTH = lfts_pkg::COUNT_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  lfts_in_if.sink                         in_ch,
  lfts_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [lfts_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lfts_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import lfts_pkg::*;

  logic              in_v_r, out_v_r, advance;
  item_t             item_r;
  result_t           res_r, res_nxt;
  logic [BASE_W-1:0] base_r;
  logic [PPR_W-1:0]  ppr_r;
  logic              entry;
  reach_t            reach;
  logic [3:0][COUNT_WIDTH-1:0] enc;
  logic [3:0][COUNT_WIDTH-1:0] snap;

  assign advance     = in_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready = !in_v_r || advance;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      enc[i] = item_r.enc[i][COUNT_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item_r.func       <= func_t'(in_ch.func);
      item_r.line_code  <= in_ch.line_code;
      item_r.turn_cross <= in_ch.turn_cross;
      item_r.enc        <= {in_ch.enc_d, in_ch.enc_c, in_ch.enc_b, in_ch.enc_a};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= BASE_SPEED_RESET;
      ppr_r  <= PPR_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BASE_SPEED:     base_r <= cfg_wdata[BASE_W-1:0];
        CFG_PULSES_PER_REV: ppr_r  <= cfg_wdata[PPR_W-1:0];
        default: ;
      endcase
    end
  end

  lfts_delta #(.COUNT_WIDTH(COUNT_WIDTH)) u_delta (
    .enc            (enc),
    .snap           (snap),
    .entry          (entry),
    .pulses_per_rev (ppr_r),
    .reach          (reach)
  );

  lfts_ctrl #(.COUNT_WIDTH(COUNT_WIDTH)) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (advance),
    .item       (item_r),
    .enc        (enc),
    .base_speed (base_r),
    .reach      (reach),
    .entry      (entry),
    .snap       (snap),
    .result     (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.drive_mask   = res_r.drive_mask;
  assign out_ch.speed_a      = res_r.speed[0];
  assign out_ch.speed_b      = res_r.speed[1];
  assign out_ch.speed_c      = res_r.speed[2];
  assign out_ch.speed_d      = res_r.speed[3];
  assign out_ch.mode_now     = res_r.mode_now;
  assign out_ch.crosses_seen = res_r.crosses_seen;

  `LFTS_ASSERT_SAME(a_off_drives_none, clk, rst_n,
    out_v_r && res_r.mode_now == MODE_OFF, res_r.drive_mask == 4'h0)
  `LFTS_ASSERT_SAME(a_undriven_speed_zero, clk, rst_n,
    out_v_r,
    (res_r.drive_mask[0] || res_r.speed[0] == '0) && (res_r.drive_mask[1] || res_r.speed[1] == '0)
    && (res_r.drive_mask[2] || res_r.speed[2] == '0)
    && (res_r.drive_mask[3] || res_r.speed[3] == '0))
  `LFTS_ASSERT_NEXT(a_cross_step, clk, rst_n,
    advance,
    res_r.crosses_seen == $past(res_nxt.crosses_seen)
    && (res_r.crosses_seen == $past(u_ctrl.cross_r)
        || res_r.crosses_seen == CROSS_W'($past(u_ctrl.cross_r) + 1'b1)))
endmodule
